@@ rtl/swrm_pkg.sv @@
// Shared types, constants and CRC-8 helper for the single-wire
// request/response master. No dependencies.
package swrm_pkg;

  // Session phase codes
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_START    = 3'd1;
  localparam logic [2:0] PH_REQUEST  = 3'd2;
  localparam logic [2:0] PH_WAIT     = 3'd3;
  localparam logic [2:0] PH_RESPONSE = 3'd4;
  localparam logic [2:0] PH_STOP     = 3'd5;

  // Input opcodes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Configuration register indexes
  localparam logic CFG_CRC_SEED     = 1'b0;
  localparam logic CFG_ERROR_WARMUP = 1'b1;

  // Configuration reset values
  localparam logic [7:0] CRC_SEED_RST     = 8'hAC;
  localparam logic [9:0] ERROR_WARMUP_RST = 10'd100;

  // CRC polynomial and slot lengths
  localparam logic [7:0] CRC_POLY       = 8'h07;
  localparam logic [5:0] START_SLOTS    = 6'd1;
  localparam logic [5:0] REQUEST_SLOTS  = 6'd16;
  localparam logic [5:0] WAIT_SLOTS     = 6'd2;
  localparam logic [5:0] RESPONSE_SLOTS = 6'd32;
  localparam logic [5:0] STOP_SLOTS     = 6'd2;

  // One input item
  typedef struct packed {
    logic       opcode;
    logic [7:0] request_byte;
    logic       pin_sample;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic        line_level;
    logic        line_drive;
    logic        busy_res;
    logic        done_res;
    logic        crc_ok;
    logic [23:0] payload;
    logic [31:0] sessions_seen;
    logic [31:0] crc_errors;
  } res_t;

  // Configuration write
  typedef struct packed {
    logic       wr;
    logic       index;
    logic [9:0] data;
  } cfg_wr_t;

  // CRC-8, MSB first, no reflection, one byte
  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] v);
    logic [7:0] c;
    c = crc ^ v;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/swrm_in_reg.sv @@
// Input register stage for the single-wire master.
// Depends on swrm_pkg for the item type.
module swrm_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          stall_o,
  input  swrm_pkg::cmd_t cmd_i,
  output logic          valid_o,
  input  logic          take_i,
  output swrm_pkg::cmd_t cmd_o
);

  logic           valid_q, valid_d;
  swrm_pkg::cmd_t cmd_q;
  logic           load;

  // Hold a waiting item until the engine takes it
  assign stall_o = valid_q && !take_i;
  assign load    = valid_i && !stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q <= cmd_i;
    end
  end

  assign valid_o = valid_q;
  assign cmd_o   = cmd_q;

endmodule

@@ rtl/swrm_engine.sv @@
// Session state, configuration registers and per-tick next-state logic.
// Depends on swrm_pkg for phase codes, types and the CRC-8 function.
module swrm_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  swrm_pkg::cfg_wr_t cfg_i,
  input  logic             fire_i,
  input  swrm_pkg::cmd_t    cmd_i,
  output swrm_pkg::res_t    res_o
);

  logic [7:0]  seed_q;
  logic [9:0]  warm_q;
  logic [2:0]  phase_q, phase_d;
  logic [5:0]  slot_q, slot_d, slot_dec;
  logic [31:0] shift_q, shift_d, word;
  logic        lvl_q, lvl_d, en_q, en_d;
  logic [23:0] pay_q, pay_d;
  logic        ok_q, ok_d;
  logic [31:0] ses_q, ses_d, err_q, err_d;
  logic        done;
  logic [7:0]  req_crc, rsp_crc;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= swrm_pkg::CRC_SEED_RST;
      warm_q <= swrm_pkg::ERROR_WARMUP_RST;
    end else if (cfg_i.wr) begin
      case (cfg_i.index)
        swrm_pkg::CFG_CRC_SEED:     seed_q <= cfg_i.data[7:0];
        swrm_pkg::CFG_ERROR_WARMUP: warm_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign slot_dec = slot_q - 6'd1;
  assign word     = {shift_q[30:0], cmd_i.pin_sample};
  assign req_crc  = swrm_pkg::crc8_step(seed_q, cmd_i.request_byte);
  assign rsp_crc  = swrm_pkg::crc8_step(
                      swrm_pkg::crc8_step(
                        swrm_pkg::crc8_step(seed_q, word[31:24]), word[23:16]),
                      word[15:8]);

  // Advance the session by one tick or restart it
  always_comb begin
    phase_d = phase_q;
    slot_d  = slot_q;
    shift_d = shift_q;
    lvl_d   = lvl_q;
    en_d    = en_q;
    pay_d   = pay_q;
    ok_d    = ok_q;
    ses_d   = ses_q;
    err_d   = err_q;
    done    = 1'b0;
    if (cmd_i.opcode == swrm_pkg::OP_START) begin
      phase_d = swrm_pkg::PH_START;
      shift_d = {cmd_i.request_byte, req_crc, 16'h0000};
      slot_d  = swrm_pkg::START_SLOTS;
      en_d    = 1'b1;
      lvl_d   = 1'b0;
    end else if (phase_q != swrm_pkg::PH_IDLE) begin
      slot_d = slot_dec;
      case (phase_q)
        swrm_pkg::PH_START: begin
          if (slot_dec == 6'd0) begin
            slot_d  = swrm_pkg::REQUEST_SLOTS;
            phase_d = swrm_pkg::PH_REQUEST;
          end
        end
        swrm_pkg::PH_REQUEST: begin
          lvl_d   = shift_q[31];
          shift_d = {shift_q[30:0], 1'b0};
          if (slot_dec == 6'd0) begin
            slot_d  = swrm_pkg::WAIT_SLOTS;
            phase_d = swrm_pkg::PH_WAIT;
          end
        end
        swrm_pkg::PH_WAIT: begin
          if (slot_dec == 6'd0) begin
            slot_d  = swrm_pkg::RESPONSE_SLOTS;
            phase_d = swrm_pkg::PH_RESPONSE;
          end
          // release the line one slot before the response
          if (slot_dec == 6'd1) begin
            en_d  = 1'b0;
            lvl_d = 1'b1;
          end
        end
        swrm_pkg::PH_RESPONSE: begin
          shift_d = word;
          if (slot_dec == 6'd0) begin
            slot_d  = swrm_pkg::STOP_SLOTS;
            phase_d = swrm_pkg::PH_STOP;
            lvl_d   = 1'b1;
            en_d    = 1'b1;
            ses_d   = ses_q + 32'd1;
            pay_d   = word[31:8];
            ok_d    = (rsp_crc == word[7:0]);
            if (!ok_d && (ses_d > {22'd0, warm_q})) begin
              err_d = err_q + 32'd1;
            end
            done = 1'b1;
          end
        end
        swrm_pkg::PH_STOP: begin
          if (slot_dec == 6'd0) begin
            phase_d = swrm_pkg::PH_IDLE;
          end
        end
        default: begin
          phase_d = swrm_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // Commit state when an item passes through
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= swrm_pkg::PH_IDLE;
      slot_q  <= 6'd0;
      shift_q <= 32'd0;
      lvl_q   <= 1'b1;
      en_q    <= 1'b1;
      pay_q   <= 24'd0;
      ok_q    <= 1'b0;
      ses_q   <= 32'd0;
      err_q   <= 32'd0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      slot_q  <= slot_d;
      shift_q <= shift_d;
      lvl_q   <= lvl_d;
      en_q    <= en_d;
      pay_q   <= pay_d;
      ok_q    <= ok_d;
      ses_q   <= ses_d;
      err_q   <= err_d;
    end
  end

  assign res_o.line_level    = lvl_d;
  assign res_o.line_drive    = en_d;
  assign res_o.busy_res      = (phase_d != swrm_pkg::PH_IDLE);
  assign res_o.done_res      = done;
  assign res_o.crc_ok        = ok_d;
  assign res_o.payload       = pay_d;
  assign res_o.sessions_seen = ses_d;
  assign res_o.crc_errors    = err_d;

endmodule

@@ rtl/swrm_out_reg.sv @@
// Result register for the single-wire master.
// Depends on swrm_pkg for the result type.
module swrm_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  swrm_pkg::res_t res_i,
  output logic          valid_o,
  input  logic          stall_i,
  output swrm_pkg::res_t res_o
);

  logic           valid_q;
  swrm_pkg::res_t res_q;

  // Space when empty or when the held result leaves this cycle
  assign ready_o = !valid_q || !stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

@@ rtl/single_wire_request_response_master_top.sv @@
// An item passes through the input register and then the result register.
// One item per cycle without an output stall; a tick needs a shift, a count and CRC-8.
// A stall on the output holds the result register and then the input register.
// Reset (async, active low): phase idle, line driven high, counters and payload zero,
// crc_seed 0xAC, error_warmup 100. Configuration writes are always ready.
module single_wire_request_response_master_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [7:0]  request_byte_i,
  input  logic        pin_sample_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        line_level_o,
  output logic        line_drive_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic        crc_ok_o,
  output logic [23:0] payload_o,
  output logic [31:0] sessions_seen_o,
  output logic [31:0] crc_errors_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [9:0]  cfg_data_i
);

  swrm_pkg::cmd_t    cmd_in, cmd_q;
  swrm_pkg::res_t    res_d, res_q;
  swrm_pkg::cfg_wr_t cfg;
  logic              cmd_valid, out_ready, fire;

  assign cmd_in.opcode       = opcode_i;
  assign cmd_in.request_byte = request_byte_i;
  assign cmd_in.pin_sample   = pin_sample_i;

  assign cfg_ready_o = 1'b1;
  assign cfg.wr      = cfg_valid_i && cfg_ready_o;
  assign cfg.index   = cfg_index_i;
  assign cfg.data    = cfg_data_i;

  // Advance an item when the result register has room
  assign fire = cmd_valid && out_ready;

  swrm_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .cmd_i   (cmd_in),
    .valid_o (cmd_valid),
    .take_i  (fire),
    .cmd_o   (cmd_q)
  );

  swrm_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .fire_i (fire),
    .cmd_i  (cmd_q),
    .res_o  (res_d)
  );

  swrm_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cmd_valid),
    .ready_o (out_ready),
    .res_i   (res_d),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .res_o   (res_q)
  );

  assign line_level_o    = res_q.line_level;
  assign line_drive_o    = res_q.line_drive;
  assign busy_res_o      = res_q.busy_res;
  assign done_res_o      = res_q.done_res;
  assign crc_ok_o        = res_q.crc_ok;
  assign payload_o       = res_q.payload;
  assign sessions_seen_o = res_q.sessions_seen;
  assign crc_errors_o    = res_q.crc_errors;

endmodule

@@ rtl/swrm_checker.sv @@
// Port-level checks for the single-wire master, bound to the top level.
// Depends only on the top level's ports.
module swrm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        line_level_o,
  input logic        line_drive_o,
  input logic        busy_res_o,
  input logic        done_res_o
);

  // Keep a stalled result presented
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Flag completion only inside a running session, with the line driven high
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> busy_res_o && line_drive_o && line_level_o)
    else $error("done outside stop phase");

  // Drive the line high whenever the master is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !busy_res_o |-> line_drive_o && line_level_o)
    else $error("idle line not driven high");

  // Report a released line as high
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !line_drive_o |-> line_level_o && busy_res_o)
    else $error("released line reported low or idle");

endmodule

bind single_wire_request_response_master_top swrm_checker u_swrm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .line_level_o (line_level_o),
  .line_drive_o (line_drive_o),
  .busy_res_o   (busy_res_o),
  .done_res_o   (done_res_o)
);

@@ tb/testbench.sv @@
// Self-checking bench for the single-wire request/response master: drives
// start and tick transfers, predicts every status result and checks them.
// Depends on swrm_pkg and single_wire_request_response_master_top.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PCT    = 34;
  localparam int SETTLE      = 5;
  // Ticks from a start to the last stop slot, and the response window
  localparam int SESSION_TICKS = 53;
  localparam int RESP_FIRST    = 20;
  localparam int RESP_LAST     = 51;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic        opcode_i       = swrm_pkg::OP_TICK;
  logic [7:0]  request_byte_i = 8'h00;
  logic        pin_sample_i   = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic        line_level_o;
  logic        line_drive_o;
  logic        busy_res_o;
  logic        done_res_o;
  logic        crc_ok_o;
  logic [23:0] payload_o;
  logic [31:0] sessions_seen_o;
  logic [31:0] crc_errors_o;
  logic        cfg_valid_i    = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i    = swrm_pkg::CFG_CRC_SEED;
  logic [9:0]  cfg_data_i     = 10'd0;

  single_wire_request_response_master_top dut (.*);

  // Predicted block state and configuration
  logic [2:0]  ses_phase;
  logic [5:0]  ses_slots;
  logic [31:0] ses_shift;
  logic        ses_level;
  logic        ses_drive;
  logic [23:0] ses_payload;
  logic        ses_crc_ok;
  logic [31:0] ses_count;
  logic [31:0] ses_errors;
  logic [7:0]  seed_reg;
  logic [9:0]  warmup_reg;

  swrm_pkg::res_t line_status_q[$];
  bit   idle_on = 1'b1;
  int   mismatches = 0;
  int   items_sent = 0;
  int   results_seen = 0;
  int   done_seen = 0;
  int   cycles = 0;

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Random backpressure on the result side
  always @(posedge clk_i) begin
    out_stall_i <= idle_on && ($urandom_range(99) < IDLE_PCT);
  end

  // CRC-8, poly 0x07, MSB first
  function automatic logic [7:0] crc8_next(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    repeat (8) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ 8'h07) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

  // Advance the predicted session by one input transfer and queue the status
  task automatic step_session(input logic op, input logic [7:0] rb, input logic pin);
    swrm_pkg::res_t r;
    logic [7:0]     c;
    logic           done;
    done = 1'b0;
    if (op == swrm_pkg::OP_START) begin
      ses_phase = swrm_pkg::PH_START;
      ses_shift = {rb, crc8_next(seed_reg, rb), 16'h0000};
      ses_slots = swrm_pkg::START_SLOTS;
      ses_drive = 1'b1;
      ses_level = 1'b0;
    end else if (ses_phase != swrm_pkg::PH_IDLE) begin
      ses_slots = ses_slots - 6'd1;
      case (ses_phase)
        swrm_pkg::PH_START: begin
          if (ses_slots == 6'd0) begin
            ses_slots = swrm_pkg::REQUEST_SLOTS;
            ses_phase = swrm_pkg::PH_REQUEST;
          end
        end
        swrm_pkg::PH_REQUEST: begin
          ses_level = ses_shift[31];
          ses_shift = ses_shift << 1;
          if (ses_slots == 6'd0) begin
            ses_slots = swrm_pkg::WAIT_SLOTS;
            ses_phase = swrm_pkg::PH_WAIT;
          end
        end
        swrm_pkg::PH_WAIT: begin
          if (ses_slots == 6'd0) begin
            ses_slots = swrm_pkg::RESPONSE_SLOTS;
            ses_phase = swrm_pkg::PH_RESPONSE;
          end
          // release the line on the first wait slot
          if (ses_slots == 6'd1) begin
            ses_drive = 1'b0;
            ses_level = 1'b1;
          end
        end
        swrm_pkg::PH_RESPONSE: begin
          ses_shift = {ses_shift[30:0], pin};
          if (ses_slots == 6'd0) begin
            ses_slots   = swrm_pkg::STOP_SLOTS;
            ses_phase   = swrm_pkg::PH_STOP;
            ses_level   = 1'b1;
            ses_drive   = 1'b1;
            done        = 1'b1;
            ses_count   = ses_count + 32'd1;
            ses_payload = ses_shift[31:8];
            c = crc8_next(seed_reg, ses_shift[31:24]);
            c = crc8_next(c, ses_shift[23:16]);
            c = crc8_next(c, ses_shift[15:8]);
            ses_crc_ok = (c == ses_shift[7:0]);
            if (!ses_crc_ok && ses_count > {22'd0, warmup_reg}) begin
              ses_errors = ses_errors + 32'd1;
            end
          end
        end
        swrm_pkg::PH_STOP: begin
          if (ses_slots == 6'd0) begin
            ses_phase = swrm_pkg::PH_IDLE;
          end
        end
        default: ses_phase = swrm_pkg::PH_IDLE;
      endcase
    end
    r.line_level    = ses_level;
    r.line_drive    = ses_drive;
    r.busy_res      = (ses_phase != swrm_pkg::PH_IDLE);
    r.done_res      = done;
    r.crc_ok        = ses_crc_ok;
    r.payload       = ses_payload;
    r.sessions_seen = ses_count;
    r.crc_errors    = ses_errors;
    line_status_q.push_back(r);
  endtask

  task automatic cmp_field(input string name, input logic [31:0] want,
                           input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, want, got);
      end
    end
  endtask

  // Check each result transfer against the oldest prediction
  initial begin
    swrm_pkg::res_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        results_seen++;
        if (line_status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result transfer with nothing expected", $realtime);
          end
        end else begin
          want = line_status_q.pop_front();
          if (want.done_res) done_seen++;
          cmp_field("line_level", want.line_level, line_level_o);
          cmp_field("line_drive", want.line_drive, line_drive_o);
          cmp_field("busy_res", want.busy_res, busy_res_o);
          cmp_field("done_res", want.done_res, done_res_o);
          cmp_field("crc_ok", want.crc_ok, crc_ok_o);
          cmp_field("payload", want.payload, payload_o);
          cmp_field("sessions_seen", want.sessions_seen, sessions_seen_o);
          cmp_field("crc_errors", want.crc_errors, crc_errors_o);
        end
      end
    end
  end

  // Send one input transfer; returns at the edge that accepts it
  task automatic send_cmd(input logic op, input logic [7:0] rb, input logic pin);
    logic took;
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    request_byte_i <= rb;
    pin_sample_i   <= pin;
    step_session(op, rb, pin);
    do begin
      @(negedge clk_i);
      took = !in_stall_o;
      @(posedge clk_i);
    end while (!took);
    items_sent++;
  endtask

  // Run the session out, drop valid and wait for every result
  task automatic drain_to_idle();
    while (ses_phase != swrm_pkg::PH_IDLE) begin
      send_cmd(swrm_pkg::OP_TICK, 8'($urandom), 1'($urandom));
    end
    in_valid_i <= 1'b0;
    while (line_status_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [9:0] data);
    logic took;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(negedge clk_i);
      took = cfg_ready_o;
      @(posedge clk_i);
    end while (!took);
    if (idx == swrm_pkg::CFG_CRC_SEED) seed_reg = data[7:0];
    else warmup_reg = data;
  endtask

  task automatic set_config(input logic [7:0] seed, input logic [9:0] warmup);
    write_reg(swrm_pkg::CFG_CRC_SEED, {2'b00, seed});
    write_reg(swrm_pkg::CFG_ERROR_WARMUP, warmup);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly complete sessions with random responses, plus cut-off sessions
  // and ticks into an idle or half-done session
  task automatic run_traffic(input int n);
    int          sent;
    int          kind;
    int          cut;
    int          idle_ticks;
    logic [31:0] word;
    logic [7:0]  c;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        word = $urandom;
        if ($urandom_range(1) == 1) begin
          c = crc8_next(seed_reg, word[31:24]);
          c = crc8_next(c, word[23:16]);
          word[7:0] = crc8_next(c, word[15:8]);
        end
        send_cmd(swrm_pkg::OP_START, 8'($urandom), 1'($urandom));
        for (int t = 1; t <= SESSION_TICKS; t++) begin
          send_cmd(swrm_pkg::OP_TICK, 8'($urandom),
                   (t >= RESP_FIRST && t <= RESP_LAST) ? word[RESP_LAST - t]
                                                       : 1'($urandom));
        end
        sent += SESSION_TICKS + 1;
      end else if (kind < 88) begin
        cut = $urandom_range(1, SESSION_TICKS - 1);
        send_cmd(swrm_pkg::OP_START, 8'($urandom), 1'($urandom));
        repeat (cut) send_cmd(swrm_pkg::OP_TICK, 8'($urandom), 1'($urandom));
        sent += cut + 1;
      end else begin
        idle_ticks = $urandom_range(1, 6);
        repeat (idle_ticks) send_cmd(swrm_pkg::OP_TICK, 8'($urandom), 1'($urandom));
        sent += idle_ticks;
      end
    end
  endtask

  // Ticks while idle with extreme unused fields: nothing may move
  task automatic test_idle_ticks();
    send_cmd(swrm_pkg::OP_TICK, 8'h00, 1'b0);
    send_cmd(swrm_pkg::OP_TICK, 8'hFF, 1'b1);
    send_cmd(swrm_pkg::OP_TICK, 8'hA5, 1'b1);
    send_cmd(swrm_pkg::OP_TICK, 8'h5A, 1'b0);
  endtask

  // Restart while busy, in the start slot and mid-request
  task automatic test_start_abort();
    send_cmd(swrm_pkg::OP_START, 8'h00, 1'b1);
    send_cmd(swrm_pkg::OP_START, 8'hFF, 1'b0);
    repeat (5) send_cmd(swrm_pkg::OP_TICK, 8'hFF, 1'b1);
    send_cmd(swrm_pkg::OP_START, 8'h81, 1'b1);
    repeat (3) send_cmd(swrm_pkg::OP_TICK, 8'h00, 1'b0);
    send_cmd(swrm_pkg::OP_START, 8'h7E, 1'b0);
    repeat (4) send_cmd(swrm_pkg::OP_TICK, 8'h3C, 1'b1);
    drain_to_idle();
  endtask

  // Full rate on both sides for a long stretch
  task automatic test_no_idle(input int n);
    idle_on = 1'b0;
    run_traffic(n);
    idle_on = 1'b1;
  endtask

  // Hold the sender until every prediction has been matched, then resume
  task automatic test_sender_pause(input int n);
    run_traffic(n);
    in_valid_i <= 1'b0;
    while (line_status_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    run_traffic(n);
  endtask

  initial begin
    ses_phase   = swrm_pkg::PH_IDLE;
    ses_slots   = 6'd0;
    ses_shift   = 32'd0;
    ses_level   = 1'b1;
    ses_drive   = 1'b1;
    ses_payload = 24'd0;
    ses_crc_ok  = 1'b0;
    ses_count   = 32'd0;
    ses_errors  = 32'd0;
    seed_reg    = swrm_pkg::CRC_SEED_RST;
    warmup_reg  = swrm_pkg::ERROR_WARMUP_RST;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_ticks();
    test_start_abort();
    // reset configuration
    run_traffic(200);
    drain_to_idle();
    set_config(8'h00, 10'd0);
    run_traffic(200);
    drain_to_idle();
    set_config(8'hFF, 10'd1023);
    test_no_idle(200);
    drain_to_idle();
    set_config(8'($urandom), 10'd2);
    test_sender_pause(110);
    drain_to_idle();

    $display("Sent %0d transfers, checked %0d results, %0d sessions completed.",
             items_sent, results_seen, done_seen);
    $display("Four CRC seed and warmup settings; %0d counted CRC errors, %0d mismatches.",
             ses_errors, mismatches);
    if (mismatches == 0 && line_status_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
